FILE: src/hmmd_pkg.sv
// Package for the handheld memory map decoder.
// Holds the beat types, target codes, address map constants and shared sizes.
// No dependencies.
package hmmd_pkg;

	localparam int WRAM_BYTES = 8192;
	localparam int WRAM_AW    = $clog2(WRAM_BYTES);
	localparam int HRAM_BYTES = 127;
	localparam int HRAM_AW    = $clog2(HRAM_BYTES);
	localparam logic [7:0] DMA_LENGTH = 8'd160;
	localparam logic [7:0] DMA_PAGE_MAX = 8'hF1;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_IDLE  = 2'd3;

	localparam logic [3:0] TGT_NONE    = 4'd0;
	localparam logic [3:0] TGT_BOOT    = 4'd1;
	localparam logic [3:0] TGT_CART    = 4'd2;
	localparam logic [3:0] TGT_VIDMEM  = 4'd3;
	localparam logic [3:0] TGT_JOYPAD  = 4'd4;
	localparam logic [3:0] TGT_TIMER   = 4'd5;
	localparam logic [3:0] TGT_IF      = 4'd6;
	localparam logic [3:0] TGT_VIDREG  = 4'd7;
	localparam logic [3:0] TGT_AUDIO   = 4'd8;
	localparam logic [3:0] TGT_IE      = 4'd9;
	localparam logic [3:0] TGT_WRAM    = 4'd10;
	localparam logic [3:0] TGT_HRAM    = 4'd11;
	localparam logic [3:0] TGT_DMAREG  = 4'd12;
	localparam logic [3:0] TGT_BLOCKED = 4'd13;

	localparam logic [15:0] ADDR_BOOT_END = 16'h0100;
	localparam logic [15:0] ADDR_VRAM     = 16'h8000;
	localparam logic [15:0] ADDR_CART_RAM = 16'hA000;
	localparam logic [15:0] ADDR_WRAM     = 16'hC000;
	localparam logic [15:0] ADDR_ECHO     = 16'hE000;
	localparam logic [15:0] ADDR_OAM      = 16'hFE00;
	localparam logic [15:0] ADDR_UNUSABLE = 16'hFEA0;
	localparam logic [15:0] ADDR_IO       = 16'hFF00;
	localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
	localparam logic [15:0] ADDR_IE       = 16'hFFFF;
	localparam logic [15:0] ADDR_DMA      = 16'hFF46;
	localparam logic [15:0] ECHO_OFFSET   = 16'h2000;

	localparam logic REG_CART = 1'b0;

	typedef enum logic [1:0] {
		RD_IMM,
		RD_WRAM,
		RD_HRAM
	} rd_sel_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  elapsed_cycles;
	} in_t;

	typedef struct packed {
		logic [3:0]  target;
		logic [15:0] target_address;
		logic [7:0]  read_data;
		logic        forward_access;
		logic        dma_start;
		logic [7:0]  dma_page;
		logic        dma_busy;
	} out_t;

	typedef struct packed {
		logic       boot;
		logic       dma_active;
		logic [7:0] dma_left;
		logic [7:0] dma_src;
	} state_t;

	typedef struct packed {
		out_t    res;
		rd_sel_t rd_sel;
		logic    wram_en;
		logic    hram_en;
		logic    ram_we;
		state_t  nxt;
	} dec_t;

endpackage

FILE: src/hmmd_ram.sv
// Single-port synchronous RAM with registered read data.
// Generic; used for work RAM and high RAM. No package dependency.
module hmmd_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wdata;
		end
		if (en && !we) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/hmmd_decode.sv
// Address decode and next-state logic for one bus beat.
// Depends on hmmd_pkg for beat types, target codes and the address map.
module hmmd_decode (
	input  hmmd_pkg::in_t    item,
	input  hmmd_pkg::state_t st,
	input  logic             cart,
	output hmmd_pkg::dec_t   dec
);

	function automatic logic [3:0] io_target(input logic [15:0] a);
		logic [3:0] t;
		t = hmmd_pkg::TGT_NONE;
		if (a == hmmd_pkg::ADDR_IO) t = hmmd_pkg::TGT_JOYPAD;
		else if (a >= 16'hFF04 && a <= 16'hFF07) t = hmmd_pkg::TGT_TIMER;
		else if (a == 16'hFF0F) t = hmmd_pkg::TGT_IF;
		else if (a == hmmd_pkg::ADDR_DMA) t = hmmd_pkg::TGT_DMAREG;
		else if (a >= 16'hFF40 && a <= 16'hFF4B) t = hmmd_pkg::TGT_VIDREG;
		else if (a >= 16'hFF10 && a < 16'hFF40) t = hmmd_pkg::TGT_AUDIO;
		return t;
	endfunction

	logic [15:0] a;
	logic [1:0]  op;
	logic        isw;
	logic        boot_now;
	logic [3:0]  io_tgt;

	assign a      = item.address;
	assign op     = item.operation;
	assign isw    = (op == hmmd_pkg::OP_WRITE);
	assign io_tgt = io_target(a);

	always_comb begin
		dec                    = '0;
		dec.nxt                = st;
		dec.rd_sel             = hmmd_pkg::RD_IMM;
		dec.ram_we             = isw;
		dec.res.target         = hmmd_pkg::TGT_NONE;
		dec.res.target_address = a;
		boot_now               = st.boot && (a != hmmd_pkg::ADDR_BOOT_END);
		priority if (op == hmmd_pkg::OP_TICK) begin
			dec.res.target_address = '0;
			if (st.dma_active) begin
				if (st.dma_left <= item.elapsed_cycles) begin
					dec.nxt.dma_left   = '0;
					dec.nxt.dma_active = 1'b0;
				end else begin
					dec.nxt.dma_left = st.dma_left - item.elapsed_cycles;
				end
			end
		end else if (op == hmmd_pkg::OP_IDLE) begin
			dec.res.target_address = '0;
		end else if (st.dma_active && a < hmmd_pkg::ADDR_IO) begin
			dec.res.target = hmmd_pkg::TGT_BLOCKED;
			if (!isw) dec.res.read_data = 8'hFF;
		end else if (a < hmmd_pkg::ADDR_VRAM
				|| (a >= hmmd_pkg::ADDR_CART_RAM && a < hmmd_pkg::ADDR_WRAM)) begin
			if (!isw) begin
				dec.nxt.boot = boot_now;
				if (boot_now && a < hmmd_pkg::ADDR_BOOT_END) begin
					dec.res.target         = hmmd_pkg::TGT_BOOT;
					dec.res.forward_access = 1'b1;
				end else begin
					dec.res.target         = hmmd_pkg::TGT_CART;
					dec.res.forward_access = cart;
				end
			end else begin
				dec.res.target         = hmmd_pkg::TGT_CART;
				dec.res.forward_access = !st.boot && cart;
			end
		end else if (a < hmmd_pkg::ADDR_CART_RAM
				|| (a >= hmmd_pkg::ADDR_OAM && a < hmmd_pkg::ADDR_UNUSABLE)) begin
			dec.res.target         = hmmd_pkg::TGT_VIDMEM;
			dec.res.forward_access = 1'b1;
		end else if (a < hmmd_pkg::ADDR_OAM) begin
			if (a >= hmmd_pkg::ADDR_ECHO) dec.res.target_address = a - hmmd_pkg::ECHO_OFFSET;
			dec.res.target = hmmd_pkg::TGT_WRAM;
			dec.wram_en    = 1'b1;
			if (!isw) dec.rd_sel = hmmd_pkg::RD_WRAM;
		end else if (a < hmmd_pkg::ADDR_IO) begin
			if (!isw) dec.res.read_data = 8'hFF;
		end else if (a < hmmd_pkg::ADDR_HRAM) begin
			dec.res.target = io_tgt;
			if (io_tgt == hmmd_pkg::TGT_DMAREG) begin
				if (isw) begin
					dec.nxt.dma_src = item.write_data;
					if (item.write_data <= hmmd_pkg::DMA_PAGE_MAX) begin
						dec.res.dma_start  = 1'b1;
						dec.nxt.dma_active = 1'b1;
						dec.nxt.dma_left   = hmmd_pkg::DMA_LENGTH;
					end
				end else begin
					dec.res.read_data = st.dma_src;
				end
			end else if (io_tgt == hmmd_pkg::TGT_NONE) begin
				if (!isw) dec.res.read_data = 8'hFF;
			end else begin
				dec.res.forward_access = 1'b1;
			end
		end else if (a < hmmd_pkg::ADDR_IE) begin
			dec.res.target = hmmd_pkg::TGT_HRAM;
			dec.hram_en    = 1'b1;
			if (!isw) dec.rd_sel = hmmd_pkg::RD_HRAM;
		end else begin
			dec.res.target         = hmmd_pkg::TGT_IE;
			dec.res.forward_access = 1'b1;
		end
		dec.res.dma_page = dec.nxt.dma_src;
		dec.res.dma_busy = dec.nxt.dma_active;
	end

endmodule

FILE: src/handheld_memory_map_decoder_top.sv
// Pipeline: an accepted beat is registered in stage 1, decoded, and registered in stage 2, which drives the output.
// Throughput: one beat per cycle; a stalled output holds both stages.
// Reset: control clears at once; then a clearing pass zeroes work RAM and
// high RAM, one entry per cycle, with in_ready low (config writes still taken).
// Top level of the memory map decoder; uses hmmd_pkg, hmmd_decode, hmmd_ram.
module handheld_memory_map_decoder_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hmmd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output hmmd_pkg::out_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	hmmd_pkg::in_t    item_s1;
	logic             valid_s1;
	hmmd_pkg::out_t   res_s2;
	hmmd_pkg::rd_sel_t sel_s2;
	logic             valid_s2;
	hmmd_pkg::state_t st_q;
	hmmd_pkg::dec_t   dec;
	logic             cart_q;
	logic [hmmd_pkg::WRAM_AW:0] clr_q;
	logic             clearing;
	logic             adv_s1;
	logic             adv_s2;
	logic             wram_en;
	logic             wram_we;
	logic [hmmd_pkg::WRAM_AW-1:0] wram_addr;
	logic [7:0]       wram_wdata;
	logic [7:0]       wram_rdata;
	logic             hram_en;
	logic             hram_we;
	logic [hmmd_pkg::HRAM_AW-1:0] hram_addr;
	logic [7:0]       hram_wdata;
	logic [7:0]       hram_rdata;

	assign clearing = !clr_q[hmmd_pkg::WRAM_AW];
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !clearing && (!valid_s1 || adv_s2);

	hmmd_decode u_decode (
		.item (item_s1),
		.st   (st_q),
		.cart (cart_q),
		.dec  (dec)
	);

	always_comb begin
		if (clearing) begin
			wram_en    = 1'b1;
			wram_we    = 1'b1;
			wram_addr  = clr_q[hmmd_pkg::WRAM_AW-1:0];
			wram_wdata = '0;
			hram_en    = (clr_q < (hmmd_pkg::WRAM_AW+1)'(hmmd_pkg::HRAM_BYTES));
			hram_we    = 1'b1;
			hram_addr  = clr_q[hmmd_pkg::HRAM_AW-1:0];
			hram_wdata = '0;
		end else begin
			wram_en    = adv_s1 && dec.wram_en;
			wram_we    = dec.ram_we;
			wram_addr  = item_s1.address[hmmd_pkg::WRAM_AW-1:0];
			wram_wdata = item_s1.write_data;
			hram_en    = adv_s1 && dec.hram_en;
			hram_we    = dec.ram_we;
			hram_addr  = item_s1.address[hmmd_pkg::HRAM_AW-1:0];
			hram_wdata = item_s1.write_data;
		end
	end

	hmmd_ram #(.DEPTH(hmmd_pkg::WRAM_BYTES), .WIDTH(8)) u_wram (
		.clk   (clk),
		.en    (wram_en),
		.we    (wram_we),
		.addr  (wram_addr),
		.wdata (wram_wdata),
		.rdata (wram_rdata)
	);

	hmmd_ram #(.DEPTH(hmmd_pkg::HRAM_BYTES), .WIDTH(8)) u_hram (
		.clk   (clk),
		.en    (hram_en),
		.we    (hram_we),
		.addr  (hram_addr),
		.wdata (hram_wdata),
		.rdata (hram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			clr_q    <= '0;
			cart_q   <= 1'b0;
			st_q     <= '{boot: 1'b1, dma_active: 1'b0, dma_left: '0, dma_src: '0};
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (in_ready) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s1) st_q <= dec.nxt;
			if (psel && penable && pwrite && pready && paddr[2] == hmmd_pkg::REG_CART) begin
				cart_q <= pwdata[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
		if (adv_s1) begin
			res_s2 <= dec.res;
			sel_s2 <= dec.rd_sel;
		end
	end

	always_comb begin
		out_data = res_s2;
		unique case (sel_s2)
			hmmd_pkg::RD_WRAM: out_data.read_data = wram_rdata;
			hmmd_pkg::RD_HRAM: out_data.read_data = hram_rdata;
			default:           out_data.read_data = res_s2.read_data;
		endcase
	end

	assign out_valid = valid_s2;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == hmmd_pkg::REG_CART) ? {31'd0, cart_q} : 32'd0;

endmodule

FILE: src/hmmd_checker.sv
// Port-level checker for the memory map decoder, bound to the top level.
// Depends on hmmd_pkg for beat types and target codes.
module hmmd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input hmmd_pkg::out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.dma_start |->
			out_data.dma_busy && out_data.target == hmmd_pkg::TGT_DMAREG
			&& out_data.dma_page <= hmmd_pkg::DMA_PAGE_MAX)
		else $error("dma start without lockout or on wrong target");

	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.target == hmmd_pkg::TGT_BLOCKED |->
			out_data.dma_busy && !out_data.forward_access
			&& out_data.target_address < hmmd_pkg::ADDR_IO)
		else $error("blocked beat outside lockout");

	a_wram_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.target == hmmd_pkg::TGT_WRAM |->
			out_data.target_address >= hmmd_pkg::ADDR_WRAM
			&& out_data.target_address < hmmd_pkg::ADDR_ECHO
			&& !out_data.forward_access)
		else $error("work RAM beat with echo not removed");

endmodule

bind handheld_memory_map_decoder_top hmmd_checker u_hmmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: tb/sv/hmmd_bus_checker.sv
// Bus checker for the handheld memory map decoder: snoops the item, result and register ports.
// Predicts each result from its own copy of RAM, boot and DMA state and counts mismatches.
// Depends on hmmd_pkg.
module hmmd_bus_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  hmmd_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  hmmd_pkg::out_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	input  logic           pready,
	output int             errors,
	output int             results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]  CART_REG_ADDR   = {hmmd_pkg::REG_CART, 2'b00};
	localparam logic [15:0] IO_TIMER_FIRST  = 16'hFF04;
	localparam logic [15:0] IO_TIMER_LAST   = 16'hFF07;
	localparam logic [15:0] IO_IF           = 16'hFF0F;
	localparam logic [15:0] IO_AUDIO_FIRST  = 16'hFF10;
	localparam logic [15:0] IO_VIDREG_FIRST = 16'hFF40;
	localparam logic [15:0] IO_VIDREG_LAST  = 16'hFF4B;

	logic [7:0]     wram_mem [hmmd_pkg::WRAM_BYTES];
	logic [7:0]     hram_mem [hmmd_pkg::HRAM_BYTES];
	logic           boot_on;
	logic           dma_on;
	logic [7:0]     dma_left;
	logic [7:0]     dma_src;
	logic           cart_on;
	hmmd_pkg::out_t bus_results_due [$];
	int             mismatches;
	hmmd_pkg::out_t due;

	function automatic logic [3:0] io_decode(logic [15:0] a);
		if (a == hmmd_pkg::ADDR_IO) return hmmd_pkg::TGT_JOYPAD;
		if (a >= IO_TIMER_FIRST && a <= IO_TIMER_LAST) return hmmd_pkg::TGT_TIMER;
		if (a == IO_IF) return hmmd_pkg::TGT_IF;
		if (a == hmmd_pkg::ADDR_DMA) return hmmd_pkg::TGT_DMAREG;
		if (a >= IO_VIDREG_FIRST && a <= IO_VIDREG_LAST) return hmmd_pkg::TGT_VIDREG;
		if (a >= IO_AUDIO_FIRST && a < IO_VIDREG_FIRST) return hmmd_pkg::TGT_AUDIO;
		return hmmd_pkg::TGT_NONE;
	endfunction

	function automatic hmmd_pkg::out_t decode_access(hmmd_pkg::in_t b);
		hmmd_pkg::out_t r;
		logic [15:0]    a;
		logic [15:0]    off;
		logic           is_wr;
		r = '0;
		a = b.address;
		is_wr = (b.operation == hmmd_pkg::OP_WRITE);
		r.target = hmmd_pkg::TGT_NONE;
		r.target_address = a;
		if (b.operation == hmmd_pkg::OP_TICK) begin
			r.target_address = '0;
			if (dma_on) begin
				if (dma_left <= b.elapsed_cycles) begin
					dma_left = '0;
					dma_on = 1'b0;
				end else begin
					dma_left = dma_left - b.elapsed_cycles;
				end
			end
		end else if (b.operation == hmmd_pkg::OP_IDLE) begin
			r.target_address = '0;
		end else if (dma_on && a < hmmd_pkg::ADDR_IO) begin
			r.target = hmmd_pkg::TGT_BLOCKED;
			if (!is_wr) r.read_data = 8'hFF;
		end else if (a < hmmd_pkg::ADDR_VRAM
				|| (a >= hmmd_pkg::ADDR_CART_RAM && a < hmmd_pkg::ADDR_WRAM)) begin
			r.target = hmmd_pkg::TGT_CART;
			if (!is_wr) begin
				if (boot_on && a == hmmd_pkg::ADDR_BOOT_END) boot_on = 1'b0;
				if (boot_on && a < hmmd_pkg::ADDR_BOOT_END) begin
					r.target = hmmd_pkg::TGT_BOOT;
					r.forward_access = 1'b1;
				end else begin
					r.forward_access = cart_on;
				end
			end else begin
				r.forward_access = !boot_on && cart_on;
			end
		end else if (a < hmmd_pkg::ADDR_CART_RAM
				|| (a >= hmmd_pkg::ADDR_OAM && a < hmmd_pkg::ADDR_UNUSABLE)) begin
			r.target = hmmd_pkg::TGT_VIDMEM;
			r.forward_access = 1'b1;
		end else if (a < hmmd_pkg::ADDR_OAM) begin
			if (a >= hmmd_pkg::ADDR_ECHO) r.target_address = a - hmmd_pkg::ECHO_OFFSET;
			r.target = hmmd_pkg::TGT_WRAM;
			off = r.target_address - hmmd_pkg::ADDR_WRAM;
			if (is_wr) wram_mem[off[hmmd_pkg::WRAM_AW-1:0]] = b.write_data;
			else r.read_data = wram_mem[off[hmmd_pkg::WRAM_AW-1:0]];
		end else if (a < hmmd_pkg::ADDR_IO) begin
			if (!is_wr) r.read_data = 8'hFF;
		end else if (a < hmmd_pkg::ADDR_HRAM) begin
			r.target = io_decode(a);
			if (r.target == hmmd_pkg::TGT_DMAREG) begin
				if (is_wr) begin
					dma_src = b.write_data;
					if (b.write_data <= hmmd_pkg::DMA_PAGE_MAX) begin
						r.dma_start = 1'b1;
						dma_on = 1'b1;
						dma_left = hmmd_pkg::DMA_LENGTH;
					end
				end else begin
					r.read_data = dma_src;
				end
			end else if (r.target == hmmd_pkg::TGT_NONE) begin
				if (!is_wr) r.read_data = 8'hFF;
			end else begin
				r.forward_access = 1'b1;
			end
		end else if (a < hmmd_pkg::ADDR_IE) begin
			r.target = hmmd_pkg::TGT_HRAM;
			off = a - hmmd_pkg::ADDR_HRAM;
			if (is_wr) hram_mem[off[hmmd_pkg::HRAM_AW-1:0]] = b.write_data;
			else r.read_data = hram_mem[off[hmmd_pkg::HRAM_AW-1:0]];
		end else begin
			r.target = hmmd_pkg::TGT_IE;
			r.forward_access = 1'b1;
		end
		r.dma_page = dma_src;
		r.dma_busy = dma_on;
		return r;
	endfunction

	function automatic string show(hmmd_pkg::out_t r);
		return $sformatf("tgt %0d addr %h rd %h fwd %b start %b page %h busy %b",
			r.target, r.target_address, r.read_data, r.forward_access,
			r.dma_start, r.dma_page, r.dma_busy);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hmmd_pkg::WRAM_BYTES; i++) wram_mem[i] = '0;
			for (int i = 0; i < hmmd_pkg::HRAM_BYTES; i++) hram_mem[i] = '0;
			boot_on = 1'b1;
			dma_on = 1'b0;
			dma_left = '0;
			dma_src = '0;
			cart_on = 1'b0;
			bus_results_due.delete();
			mismatches = 0;
			errors <= 0;
			results_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CART_REG_ADDR)
				cart_on = pwdata[0];
			if (out_valid && out_ready) begin
				if (bus_results_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing due: %s", $time, show(out_data));
					mismatches++;
				end else begin
					due = bus_results_due.pop_front();
					if (out_data !== due) begin
						if (mismatches < 10)
							$display("%0t: mismatch\n  expected %s\n  actual   %s",
								$time, show(due), show(out_data));
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				bus_results_due.push_back(decode_access(in_data));
			errors <= mismatches;
			results_pending <= bus_results_due.size();
		end
	end

endmodule

FILE: tb/sv/handheld_memory_map_decoder_top_tb.sv
// Testbench top for handheld_memory_map_decoder_top: clock, reset, register writes and beats.
// Runs a directed memory map sweep, then random phases under varied idling; verdict from the checker.
// Depends on hmmd_pkg, handheld_memory_map_decoder_top and hmmd_bus_checker.
module handheld_memory_map_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT   = 300000;
	localparam logic [2:0] CART_REG_ADDR = {hmmd_pkg::REG_CART, 2'b00};

	logic           clk = 1'b0;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	hmmd_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	hmmd_pkg::out_t out_data;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [2:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;
	int             errors;
	int             results_pending;
	int             gap_pct = 0;
	int             stall_pct = 0;
	int             cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("handheld_memory_map_decoder_top test failed");
			$finish;
		end
	end

	handheld_memory_map_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	hmmd_bus_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.errors          (errors),
		.results_pending (results_pending)
	);

	function automatic hmmd_pkg::in_t beat(logic [1:0] op, logic [15:0] addr,
		logic [7:0] data, logic [7:0] cyc);
		hmmd_pkg::in_t b;
		b.operation = op;
		b.address = addr;
		b.write_data = data;
		b.elapsed_cycles = cyc;
		return b;
	endfunction

	function automatic hmmd_pkg::in_t random_beat();
		hmmd_pkg::in_t b;
		int            pick;
		pick = $urandom_range(99);
		if (pick < 38) b.operation = hmmd_pkg::OP_READ;
		else if (pick < 72) b.operation = hmmd_pkg::OP_WRITE;
		else if (pick < 94) b.operation = hmmd_pkg::OP_TICK;
		else b.operation = hmmd_pkg::OP_IDLE;
		b.write_data = 8'($urandom);
		b.elapsed_cycles = $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom);
		case ($urandom_range(11))
			0: b.address = 16'($urandom);
			1: b.address = 16'($urandom_range(16'h7FFF));
			2: b.address = 16'($urandom_range(16'hA000, 16'hBFFF));
			3: b.address = $urandom_range(1) ? 16'($urandom_range(16'h8000, 16'h9FFF))
				: 16'($urandom_range(16'hFE00, 16'hFE9F));
			4: b.address = hmmd_pkg::ADDR_WRAM + 16'($urandom_range(31));
			5: b.address = hmmd_pkg::ADDR_ECHO + 16'($urandom_range(31));
			6: b.address = 16'($urandom_range(16'hC000, 16'hFDFF));
			7: b.address = 16'($urandom_range(16'hFEA0, 16'hFEFF));
			8: b.address = 16'($urandom_range(16'hFF00, 16'hFF7F));
			9: begin
				b.address = hmmd_pkg::ADDR_DMA;
				if ($urandom_range(1)) b.write_data = 8'($urandom_range(16'hE0, 16'hFF));
			end
			10: b.address = $urandom_range(1) ? hmmd_pkg::ADDR_HRAM + 16'($urandom_range(7))
				: 16'($urandom_range(16'hFF80, 16'hFFFE));
			default: b.address = hmmd_pkg::ADDR_IE;
		endcase
		return b;
	endfunction

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_beat(hmmd_pkg::in_t b);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_phase(logic cart, int gap, int stall, int count);
		apb_write(CART_REG_ADDR, {31'd0, cart});
		gap_pct = gap;
		stall_pct = stall;
		repeat (count) send_beat(random_beat());
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_write(CART_REG_ADDR, 32'd0);

		send_beat(beat(hmmd_pkg::OP_READ,  16'h0000, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'h00FF, 8'hFF, 8'hFF));
		send_beat(beat(hmmd_pkg::OP_WRITE, 16'h0050, 8'h3C, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  hmmd_pkg::ADDR_BOOT_END, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'h0000, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_WRITE, 16'h7FFF, 8'hFF, 8'h00));
		send_beat(beat(hmmd_pkg::OP_WRITE, 16'hC000, 8'hFF, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hE000, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_WRITE, 16'hFDFF, 8'hA5, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hDDFF, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'h8000, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_WRITE, 16'hFE9F, 8'h11, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hFEA0, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hFF00, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hFF7F, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_WRITE, 16'hFF80, 8'h5A, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hFFFE, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_WRITE, hmmd_pkg::ADDR_DMA, 8'hF2, 8'h00));
		send_beat(beat(hmmd_pkg::OP_WRITE, hmmd_pkg::ADDR_DMA, 8'hF1, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hC000, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_READ,  16'hFF80, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_TICK,  16'h0000, 8'h00, 8'd100));
		send_beat(beat(hmmd_pkg::OP_WRITE, hmmd_pkg::ADDR_DMA, 8'h00, 8'h00));
		send_beat(beat(hmmd_pkg::OP_TICK,  16'hFFFF, 8'h00, 8'hFF));
		send_beat(beat(hmmd_pkg::OP_TICK,  16'h0000, 8'h00, 8'h07));
		send_beat(beat(hmmd_pkg::OP_IDLE,  16'hFFFF, 8'hFF, 8'hFF));
		drain();

		run_phase(1'b1, 0, 0, 150);
		run_phase(1'b0, 62, 0, 150);
		run_phase(1'b1, 0, 62, 150);
		run_phase(1'b0, 6, 6, 150);
		run_phase(1'b1, 0, 0, 100);

		if (errors == 0) begin
			$display("handheld_memory_map_decoder_top test passed");
		end else begin
			$display("handheld_memory_map_decoder_top test failed");
		end
		$finish;
	end

endmodule
